[hw/rtl/pm0_pkg.sv]
// ----------------------------------------------------------------------------
// pm0_pkg
// Shared types and constants for the stack machine step unit: opcodes,
// sub-operation codes, fault codes, sequencer states and the divider request.
// ----------------------------------------------------------------------------
package pm0_pkg;

   localparam int PM0_STACK_DEPTH = 512;
   localparam int PM0_MAX_LEVEL   = 7;
   localparam int WORD_W          = 32;
   localparam int PC_W            = 9;

   typedef enum logic [3:0] {
      OP_LIT = 4'd1,
      OP_OPR = 4'd2,
      OP_LOD = 4'd3,
      OP_STO = 4'd4,
      OP_CAL = 4'd5,
      OP_RTN = 4'd6,
      OP_INC = 4'd7,
      OP_JMP = 4'd8,
      OP_JPC = 4'd9,
      OP_SYS = 4'd10
   } opcode_type;

   localparam logic [3:0] OPR_ADD = 4'd1;
   localparam logic [3:0] OPR_SUB = 4'd2;
   localparam logic [3:0] OPR_MUL = 4'd3;
   localparam logic [3:0] OPR_DIV = 4'd4;
   localparam logic [3:0] OPR_EQ  = 4'd5;
   localparam logic [3:0] OPR_NE  = 4'd6;
   localparam logic [3:0] OPR_LT  = 4'd7;
   localparam logic [3:0] OPR_LE  = 4'd8;
   localparam logic [3:0] OPR_GT  = 4'd9;
   localparam logic [3:0] OPR_GE  = 4'd10;

   localparam logic [WORD_W-1:0] SYS_WRITE = 32'd1;
   localparam logic [WORD_W-1:0] SYS_READ  = 32'd2;
   localparam logic [WORD_W-1:0] SYS_HALT  = 32'd3;

   typedef enum logic [1:0] {
      FLT_NONE    = 2'd0,
      FLT_DIV     = 2'd1,
      FLT_BOUND   = 2'd2,
      FLT_ILLEGAL = 2'd3
   } fault_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_WALK,
      S_WALKW,
      S_ADDR,
      S_LODW,
      S_STOW,
      S_CAL2,
      S_CAL3,
      S_OPR_Y,
      S_OPR_X,
      S_DIV,
      S_TOP,
      S_RTN1,
      S_RTN2,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

endpackage

[hw/rtl/pm0_div.sv]
// ----------------------------------------------------------------------------
// pm0_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. Pulses div_done once the last quotient bit is in, with div_quot valid.
// ----------------------------------------------------------------------------
module pm0_div (
   input  logic                          clock,
   input  logic                          reset,
   input  pm0_pkg::div_req_type          div_req,
   output logic                          div_done,
   output logic [pm0_pkg::WORD_W-1:0]    div_quot
);
   import pm0_pkg::*;

   localparam int CW = $clog2(WORD_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic              neg_ff;
   logic [WORD_W-1:0] q_ff;
   logic [WORD_W-1:0] r_ff;
   logic [WORD_W-1:0] mb_ff;
   logic [WORD_W:0]   rem;
   logic [WORD_W:0]   diff;
   logic [WORD_W-1:0] ma;
   logic [WORD_W-1:0] mb;

   assign ma   = div_req.dividend[WORD_W-1] ? (~div_req.dividend + 1'b1) : div_req.dividend;
   assign mb   = div_req.divisor[WORD_W-1]  ? (~div_req.divisor + 1'b1)  : div_req.divisor;
   assign rem  = {r_ff, q_ff[WORD_W-1]};
   assign diff = rem - {1'b0, mb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(WORD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         q_ff   <= ma;
         r_ff   <= '0;
         mb_ff  <= mb;
         neg_ff <= div_req.dividend[WORD_W-1] ^ div_req.divisor[WORD_W-1];
      end else if (busy_ff) begin
         q_ff <= {q_ff[WORD_W-2:0], ~diff[WORD_W]};
         r_ff <= diff[WORD_W] ? rem[WORD_W-1:0] : diff[WORD_W-1:0];
      end
   end

   assign div_done = done_ff;
   assign div_quot = neg_ff ? (~q_ff + 1'b1) : q_ff;

endmodule

[hw/rtl/pm0_stack_machine_step_unit.sv]
// ----------------------------------------------------------------------------
// pm0_stack_machine_step_unit
// Executes one P-machine instruction per request beat against a stack memory
// and reports next pc, write output, halt flag and fault code per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction (opcode, level, modifier) and the value for
//   the read call; rsp_* returns one beat per instruction.
//   After reset the unit clears the stack memory, one word per cycle; req_stall
//   stays high until that pass is done. Stack top resets to empty, frame base
//   and pc to zero, halt to clear.
//   LIT, INC, JMP, the read and halt calls and any fault found at decode go
//   from S_START to S_DONE; JPC and the write call add S_TOP, OPR adds S_OPR_Y
//   and S_OPR_X, RTN S_RTN1 and S_RTN2. LOD, STO and CAL walk one static
//   link level (up to MAX_LEVEL) per pass through S_WALK and S_WALKW, then
//   S_ADDR and S_LODW, S_STOW or S_CAL2 and S_CAL3. Divide waits in S_DIV on
//   the divider, which runs one quotient bit per cycle. A request to a halted
//   unit skips to S_DONE. Stack memory reads are registered.
//   One instruction is in flight at a time. A finished result sits in the
//   output register; the next request is accepted while it waits, and that
//   instruction completes once the receiver has lowered rsp_stall.
//   Once halted, every request returns the held pc with rsp_halted set.
// ----------------------------------------------------------------------------
module pm0_stack_machine_step_unit #(
   parameter int STACK_DEPTH = pm0_pkg::PM0_STACK_DEPTH,
   parameter int MAX_LEVEL   = pm0_pkg::PM0_MAX_LEVEL
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [3:0]                   req_opcode,
   input  logic [2:0]                   req_level,
   input  logic [pm0_pkg::WORD_W-1:0]   req_modifier,
   input  logic [pm0_pkg::WORD_W-1:0]   req_read_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pm0_pkg::PC_W-1:0]     rsp_next_pc,
   output logic                         rsp_out_valid,
   output logic [pm0_pkg::WORD_W-1:0]   rsp_out_value,
   output logic                         rsp_halted,
   output logic [1:0]                   rsp_fault_code
);
   import pm0_pkg::*;

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = SAW + 1;
   localparam int LVW = $clog2(MAX_LEVEL + 1);
   localparam int EW  = WORD_W + 2;
   localparam logic signed [EW-1:0] DEPTH_E = EW'(STACK_DEPTH);

   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic              mem_we;
   logic [SAW-1:0]    mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [SAW-1:0]    mem_raddr;

   state_type         state_ff, state_in;
   logic [SAW-1:0]    clr_ff, clr_in;
   logic [3:0]        op_ff, op_in;
   logic [LVW-1:0]    walk_ff, walk_in;
   logic [WORD_W-1:0] mod_ff, mod_in;
   logic [WORD_W-1:0] rv_ff, rv_in;
   logic [SAW-1:0]    base_ff, base_in;
   logic [SAW-1:0]    addr_ff, addr_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic signed [SAW:0] sp_ff, sp_in, nsp_ff, nsp_in;
   logic [SAW-1:0]    fb_ff, fb_in, nfb_ff, nfb_in;
   logic [PC_W-1:0]   pc_ff, pc_in, npc_ff, npc_in;
   logic              halt_ff, halt_in, nhalt_ff, nhalt_in;
   fault_type         fault_ff, fault_in;
   logic              wrote_ff, wrote_in;
   logic [WORD_W-1:0] wval_ff, wval_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PC_W-1:0]   rsp_pc_ff, rsp_pc_in;
   logic              rsp_ov_ff, rsp_ov_in;
   logic [WORD_W-1:0] rsp_val_ff, rsp_val_in;
   logic              rsp_halt_ff, rsp_halt_in;
   fault_type         rsp_fault_ff, rsp_fault_in;

   div_req_type       div_req;
   logic              div_done;
   logic [WORD_W-1:0] div_quot;

   logic signed [EW-1:0] sp_ext, mod_ext, inc_sum, cal_sum;
   logic [EW-1:0]     slot_sum, rtn_sum;
   logic [SPW-1:0]    sp_p1, sp_p2, sp_p3, sp_m1, fb_m1;
   logic              sp_full, sp_empty, sp_lt1, inc_ok, slot_ok, rd_word_ok, opr_ok;
   logic [WORD_W-1:0] opr_res;
   logic [LVW-1:0]    lv_sat;

   pm0_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // stack memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= stack_mem[mem_raddr];
   end

   assign sp_ext   = {{(EW-SPW){sp_ff[SAW]}}, sp_ff};
   assign mod_ext  = {{(EW-WORD_W){mod_ff[WORD_W-1]}}, mod_ff};
   assign inc_sum  = sp_ext + mod_ext;
   assign cal_sum  = sp_ext + EW'(3);
   assign slot_sum = {{(EW-SAW){1'b0}}, base_ff} + mod_ext;
   assign rtn_sum  = {{(EW-SAW){1'b0}}, fb_ff} + EW'(2);
   assign sp_p1    = sp_ff + SPW'(1);
   assign sp_p2    = sp_ff + SPW'(2);
   assign sp_p3    = sp_ff + SPW'(3);
   assign sp_m1    = sp_ff - SPW'(1);
   assign fb_m1    = {1'b0, fb_ff} - SPW'(1);
   assign sp_full  = (sp_ff == SPW'(STACK_DEPTH - 1));
   assign sp_empty = sp_ff[SAW];
   assign sp_lt1   = sp_ff[SAW] || (sp_ff == '0);
   assign inc_ok   = (inc_sum == '1) || (inc_sum[EW-1:SAW] == '0);
   assign slot_ok  = (slot_sum[EW-1:SAW] == '0);
   assign rd_word_ok = (rdata_ff[WORD_W-1:SAW] == '0);
   assign opr_ok   = (mod_ff[WORD_W-1:4] == '0) && (mod_ff[3:0] >= OPR_ADD)
                     && (mod_ff[3:0] <= OPR_GE);
   assign lv_sat   = (int'(req_level) > MAX_LEVEL) ? LVW'(MAX_LEVEL) : LVW'(req_level);

   always_comb begin
      opr_res = '0;
      unique case (mod_ff[3:0])
         OPR_ADD: opr_res = rdata_ff + y_ff;
         OPR_SUB: opr_res = rdata_ff - y_ff;
         OPR_MUL: opr_res = rdata_ff * y_ff;
         OPR_EQ:  opr_res = WORD_W'(rdata_ff == y_ff);
         OPR_NE:  opr_res = WORD_W'(rdata_ff != y_ff);
         OPR_LT:  opr_res = WORD_W'($signed(rdata_ff) <  $signed(y_ff));
         OPR_LE:  opr_res = WORD_W'($signed(rdata_ff) <= $signed(y_ff));
         OPR_GT:  opr_res = WORD_W'($signed(rdata_ff) >  $signed(y_ff));
         OPR_GE:  opr_res = WORD_W'($signed(rdata_ff) >= $signed(y_ff));
         default: opr_res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '1;
         fb_ff        <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         fb_ff        <= fb_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      walk_ff      <= walk_in;
      mod_ff       <= mod_in;
      rv_ff        <= rv_in;
      base_ff      <= base_in;
      addr_ff      <= addr_in;
      y_ff         <= y_in;
      nsp_ff       <= nsp_in;
      nfb_ff       <= nfb_in;
      npc_ff       <= npc_in;
      nhalt_ff     <= nhalt_in;
      fault_ff     <= fault_in;
      wrote_ff     <= wrote_in;
      wval_ff      <= wval_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_ov_ff    <= rsp_ov_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_halt_ff  <= rsp_halt_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      walk_in      = walk_ff;
      mod_in       = mod_ff;
      rv_in        = rv_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      y_in         = y_ff;
      sp_in        = sp_ff;
      nsp_in       = nsp_ff;
      fb_in        = fb_ff;
      nfb_in       = nfb_ff;
      pc_in        = pc_ff;
      npc_in       = npc_ff;
      halt_in      = halt_ff;
      nhalt_in     = nhalt_ff;
      fault_in     = fault_ff;
      wrote_in     = wrote_ff;
      wval_in      = wval_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pc_in    = rsp_pc_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_halt_in  = rsp_halt_ff;
      rsp_fault_in = rsp_fault_ff;
      req_stall    = 1'b1;
      mem_we       = 1'b0;
      mem_waddr    = sp_p1[SAW-1:0];
      mem_wdata    = '0;
      mem_raddr    = sp_ff[SAW-1:0];
      div_req      = '{start: 1'b0, dividend: rdata_ff, divisor: y_ff};

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + SAW'(1);
            if (clr_ff == SAW'(STACK_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = req_opcode;
               walk_in  = lv_sat;
               mod_in   = req_modifier;
               rv_in    = req_read_value;
               nsp_in   = sp_ff;
               nfb_in   = fb_ff;
               nhalt_in = halt_ff;
               fault_in = FLT_NONE;
               wrote_in = 1'b0;
               wval_in  = '0;
               if (halt_ff) begin
                  npc_in   = pc_ff;
                  state_in = S_DONE;
               end else begin
                  npc_in   = pc_ff + PC_W'(1);
                  state_in = S_START;
               end
            end
         end

         S_START: begin
            state_in = S_DONE;
            base_in  = fb_ff;
            unique case (op_ff)
               OP_LIT: begin
                  if (sp_full) begin
                     fault_in = FLT_BOUND;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = mod_ff;
                     nsp_in    = sp_p1;
                  end
               end
               OP_OPR: begin
                  if (!opr_ok) begin
                     fault_in = FLT_ILLEGAL;
                  end else if (sp_lt1) begin
                     fault_in = FLT_BOUND;
                  end else begin
                     state_in = S_OPR_Y;
                  end
               end
               OP_LOD: begin
                  if (sp_full) fault_in = FLT_BOUND;
                  else state_in = S_WALK;
               end
               OP_STO: begin
                  if (sp_empty) fault_in = FLT_BOUND;
                  else state_in = S_WALK;
               end
               OP_CAL: begin
                  if (cal_sum >= DEPTH_E) fault_in = FLT_BOUND;
                  else state_in = S_WALK;
               end
               OP_RTN: begin
                  if (rtn_sum >= EW'(STACK_DEPTH)) begin
                     fault_in = FLT_BOUND;
                  end else begin
                     mem_raddr = fb_ff + SAW'(1);
                     state_in  = S_RTN1;
                  end
               end
               OP_INC: begin
                  if (inc_ok) nsp_in = inc_sum[SAW:0];
                  else fault_in = FLT_BOUND;
               end
               OP_JMP: begin
                  npc_in = mod_ff[PC_W-1:0];
               end
               OP_JPC: begin
                  if (sp_empty) fault_in = FLT_BOUND;
                  else state_in = S_TOP;
               end
               OP_SYS: begin
                  if (mod_ff == SYS_WRITE) begin
                     if (sp_empty) fault_in = FLT_BOUND;
                     else state_in = S_TOP;
                  end else if (mod_ff == SYS_READ) begin
                     if (sp_full) begin
                        fault_in = FLT_BOUND;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = rv_ff;
                        nsp_in    = sp_p1;
                     end
                  end else if (mod_ff == SYS_HALT) begin
                     nhalt_in = 1'b1;
                  end else begin
                     fault_in = FLT_ILLEGAL;
                  end
               end
               default: fault_in = FLT_ILLEGAL;
            endcase
         end

         S_WALK: begin
            mem_raddr = base_ff;
            if (walk_ff == '0) state_in = S_ADDR;
            else state_in = S_WALKW;
         end

         S_WALKW: begin
            if (!rd_word_ok) begin
               fault_in = FLT_BOUND;
               state_in = S_DONE;
            end else begin
               base_in  = rdata_ff[SAW-1:0];
               walk_in  = walk_ff - LVW'(1);
               state_in = S_WALK;
            end
         end

         S_ADDR: begin
            addr_in = slot_sum[SAW-1:0];
            if (op_ff == OP_CAL) begin
               mem_we    = 1'b1;
               mem_wdata = WORD_W'(base_ff);
               state_in  = S_CAL2;
            end else if (!slot_ok) begin
               fault_in = FLT_BOUND;
               state_in = S_DONE;
            end else if (op_ff == OP_LOD) begin
               mem_raddr = slot_sum[SAW-1:0];
               state_in  = S_LODW;
            end else begin
               state_in = S_STOW;
            end
         end

         S_LODW: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
            nsp_in    = sp_p1;
            state_in  = S_DONE;
         end

         S_STOW: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = rdata_ff;
            nsp_in    = sp_m1;
            state_in  = S_DONE;
         end

         S_CAL2: begin
            mem_we    = 1'b1;
            mem_waddr = sp_p2[SAW-1:0];
            mem_wdata = WORD_W'(fb_ff);
            state_in  = S_CAL3;
         end

         S_CAL3: begin
            mem_we    = 1'b1;
            mem_waddr = sp_p3[SAW-1:0];
            mem_wdata = WORD_W'(npc_ff);
            nfb_in    = sp_p1[SAW-1:0];
            npc_in    = mod_ff[PC_W-1:0];
            state_in  = S_DONE;
         end

         S_OPR_Y: begin
            y_in      = rdata_ff;
            mem_raddr = sp_m1[SAW-1:0];
            state_in  = S_OPR_X;
         end

         S_OPR_X: begin
            if (mod_ff[3:0] == OPR_DIV) begin
               if (y_ff == '0) begin
                  fault_in = FLT_DIV;
                  state_in = S_DONE;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = sp_m1[SAW-1:0];
               mem_wdata = opr_res;
               nsp_in    = sp_m1;
               state_in  = S_DONE;
            end
         end

         S_DIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_waddr = sp_m1[SAW-1:0];
               mem_wdata = div_quot;
               nsp_in    = sp_m1;
               state_in  = S_DONE;
            end
         end

         S_TOP: begin
            nsp_in   = sp_m1;
            state_in = S_DONE;
            if (op_ff == OP_JPC) begin
               if (rdata_ff == '0) npc_in = mod_ff[PC_W-1:0];
            end else begin
               wrote_in = 1'b1;
               wval_in  = rdata_ff;
            end
         end

         S_RTN1: begin
            if (!rd_word_ok) begin
               fault_in = FLT_BOUND;
               state_in = S_DONE;
            end else begin
               nfb_in    = rdata_ff[SAW-1:0];
               mem_raddr = fb_ff + SAW'(2);
               state_in  = S_RTN2;
            end
         end

         S_RTN2: begin
            npc_in   = rdata_ff[PC_W-1:0];
            nsp_in   = fb_m1;
            state_in = S_DONE;
         end

         S_DONE: begin
            // result commit: waits for a free output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in    = npc_ff;
               rsp_fault_in = fault_ff;
               rsp_ov_in    = wrote_ff && (fault_ff == FLT_NONE);
               rsp_val_in   = (wrote_ff && (fault_ff == FLT_NONE)) ? wval_ff : '0;
               pc_in        = npc_ff;
               if (fault_ff != FLT_NONE) begin
                  halt_in     = 1'b1;
                  rsp_halt_in = 1'b1;
               end else begin
                  halt_in     = nhalt_ff;
                  rsp_halt_in = nhalt_ff;
                  sp_in       = nsp_ff;
                  fb_in       = nfb_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = rsp_pc_ff;
   assign rsp_out_valid  = rsp_ov_ff;
   assign rsp_out_value  = rsp_val_ff;
   assign rsp_halted     = rsp_halt_ff;
   assign rsp_fault_code = rsp_fault_ff;

`ifndef SYNTHESIS
   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fault_code != FLT_NONE) |-> rsp_halted)
      else $error("fault beat without halt");

   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> (rsp_fault_code == FLT_NONE) && !rsp_halted)
      else $error("write output on a halted or faulting beat");

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      (int'(sp_ff) >= -1) && (int'(sp_ff) <= STACK_DEPTH - 1))
      else $error("stack top out of range");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("stack write while idle");
`endif

endmodule

[tb/pm0_stack_machine_step_unit_test.sv]
// ----------------------------------------------------------------------------
// pm0_stack_machine_step_unit_test
// Self-checking bench for the stack machine step unit. A behavioral copy of
// the machine predicts every response beat. Instructions are generated from
// that copy's state so that long legal programs run: arithmetic, frames,
// static link walks, jumps and I/O. Both channels idle at random, and the
// receiver holds off once for a long stretch. The run ends with one fault or
// halt, followed by instructions that the halted machine must ignore.
// ----------------------------------------------------------------------------
module pm0_stack_machine_step_unit_test;
   import pm0_pkg::*;

   localparam int DEPTH      = PM0_STACK_DEPTH;
   localparam int CODE_DEPTH = 1 << PC_W;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              out_valid;
      logic [WORD_W-1:0] out_value;
      logic              halted;
      logic [1:0]        fault_code;
   } step_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [3:0]        req_opcode;
   logic [2:0]        req_level;
   logic [WORD_W-1:0] req_modifier;
   logic [WORD_W-1:0] req_read_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [PC_W-1:0]   rsp_next_pc;
   logic              rsp_out_valid;
   logic [WORD_W-1:0] rsp_out_value;
   logic              rsp_halted;
   logic [1:0]        rsp_fault_code;

   // machine state as the bench sees it
   logic [WORD_W-1:0] m_mem [DEPTH];
   int                m_sp;
   int                m_fb;
   int                m_pc;
   bit                m_halted;

   step_result_type   pending_results[$];
   int                failures;
   bit                quiet;
   bit                hold_req;
   int                stall_left;

   pm0_stack_machine_step_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_level      (req_level),
      .req_modifier   (req_modifier),
      .req_read_value (req_read_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_halted     (rsp_halted),
      .rsp_fault_code (rsp_fault_code)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[pm0_stack_machine_step_unit] ERROR");
      $finish;
   end

   function automatic bit walk_ok(input int base, input int lv, output int res);
      int b;
      b = base;
      repeat (lv) begin
         if ($signed(m_mem[b]) < 0 || m_mem[b] >= DEPTH) return 0;
         b = int'(m_mem[b]);
      end
      res = b;
      return 1;
   endfunction

   function automatic bit slot_ok(input int lv, input logic [WORD_W-1:0] mod,
                                  output int addr);
      int     b;
      longint t;
      if (!walk_ok(m_fb, lv, b)) return 0;
      t = longint'(b) + longint'($signed(mod));
      if (t < 0 || t >= DEPTH) return 0;
      addr = int'(t);
      return 1;
   endfunction

   function automatic bit return_ok();
      if (m_fb + 2 >= DEPTH) return 0;
      return !($signed(m_mem[m_fb + 1]) < 0 || m_mem[m_fb + 1] >= DEPTH);
   endfunction

   function automatic logic [WORD_W-1:0] quotient(input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] y);
      if (x == 32'h8000_0000 && y == 32'hffff_ffff) return x;
      return $signed(x) / $signed(y);
   endfunction

   // executes one instruction on the bench copy and queues the expected beat
   task automatic run_instruction(input logic [3:0] op, input logic [2:0] lv,
                                  input logic [WORD_W-1:0] mod,
                                  input logic [WORD_W-1:0] rv);
      int                nsp;
      int                a;
      int                b;
      int                npc;
      longint            n;
      fault_type         flt;
      logic              wrote;
      logic [WORD_W-1:0] wv;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] r;
      step_result_type   e;
      if (m_halted) begin
         e = '{PC_W'(m_pc), 1'b0, '0, 1'b1, FLT_NONE};
         pending_results.push_back(e);
         return;
      end
      nsp   = m_sp;
      flt   = FLT_NONE;
      wrote = 1'b0;
      wv    = '0;
      r     = '0;
      npc   = (m_pc + 1) % CODE_DEPTH;
      case (op)
         OP_LIT: begin
            if (nsp + 1 >= DEPTH) flt = FLT_BOUND;
            else begin
               nsp++;
               m_mem[nsp] = mod;
            end
         end
         OP_OPR: begin
            if ($signed(mod) < 1 || $signed(mod) > 10) flt = FLT_ILLEGAL;
            else if (nsp < 1) flt = FLT_BOUND;
            else begin
               x = m_mem[nsp - 1];
               y = m_mem[nsp];
               case (mod[3:0])
                  OPR_ADD: r = x + y;
                  OPR_SUB: r = x - y;
                  OPR_MUL: r = x * y;
                  OPR_DIV: begin
                     if (y == 0) flt = FLT_DIV;
                     else r = quotient(x, y);
                  end
                  OPR_EQ:  r = {31'b0, x == y};
                  OPR_NE:  r = {31'b0, x != y};
                  OPR_LT:  r = {31'b0, $signed(x) < $signed(y)};
                  OPR_LE:  r = {31'b0, $signed(x) <= $signed(y)};
                  OPR_GT:  r = {31'b0, $signed(x) > $signed(y)};
                  default: r = {31'b0, $signed(x) >= $signed(y)};
               endcase
               if (flt == FLT_NONE) begin
                  nsp--;
                  m_mem[nsp] = r;
               end
            end
         end
         OP_LOD: begin
            if (nsp + 1 >= DEPTH || !slot_ok(lv, mod, a)) flt = FLT_BOUND;
            else begin
               nsp++;
               m_mem[nsp] = m_mem[a];
            end
         end
         OP_STO: begin
            if (nsp < 0 || !slot_ok(lv, mod, a)) flt = FLT_BOUND;
            else begin
               m_mem[a] = m_mem[nsp];
               nsp--;
            end
         end
         OP_CAL: begin
            if (nsp + 3 >= DEPTH || !walk_ok(m_fb, lv, b)) flt = FLT_BOUND;
            else begin
               m_mem[nsp + 1] = b;
               m_mem[nsp + 2] = m_fb;
               m_mem[nsp + 3] = npc;
               m_fb = nsp + 1;
               npc = int'(mod[PC_W-1:0]);
            end
         end
         OP_RTN: begin
            if (!return_ok()) flt = FLT_BOUND;
            else begin
               npc = int'(m_mem[m_fb + 2][PC_W-1:0]);
               nsp = m_fb - 1;
               m_fb = int'(m_mem[m_fb + 1]);
            end
         end
         OP_INC: begin
            n = longint'(nsp) + longint'($signed(mod));
            if (n < -1 || n >= DEPTH) flt = FLT_BOUND;
            else nsp = int'(n);
         end
         OP_JMP: npc = int'(mod[PC_W-1:0]);
         OP_JPC: begin
            if (nsp < 0) flt = FLT_BOUND;
            else begin
               if (m_mem[nsp] == 0) npc = int'(mod[PC_W-1:0]);
               nsp--;
            end
         end
         OP_SYS: begin
            if (mod == SYS_WRITE) begin
               if (nsp < 0) flt = FLT_BOUND;
               else begin
                  wv = m_mem[nsp];
                  wrote = 1'b1;
                  nsp--;
               end
            end else if (mod == SYS_READ) begin
               if (nsp + 1 >= DEPTH) flt = FLT_BOUND;
               else begin
                  nsp++;
                  m_mem[nsp] = rv;
               end
            end else if (mod == SYS_HALT) m_halted = 1'b1;
            else flt = FLT_ILLEGAL;
         end
         default: flt = FLT_ILLEGAL;
      endcase
      if (flt != FLT_NONE) begin
         m_halted = 1'b1;
         wrote = 1'b0;
         wv = '0;
      end else m_sp = nsp;
      m_pc = npc;
      e = '{PC_W'(m_pc), wrote, wv, m_halted, flt};
      pending_results.push_back(e);
   endtask

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_instr(input logic [3:0] op, input logic [2:0] lv,
                             input logic [WORD_W-1:0] mod,
                             input logic [WORD_W-1:0] rv);
      run_instruction(op, lv, mod, rv);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_level      <= lv;
      req_modifier   <= mod;
      req_read_value <= rv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_beat();
      step_result_type e;
      if (pending_results.size() == 0) begin
         $error("response beat with no instruction outstanding");
         failures++;
         return;
      end
      e = pending_results.pop_front();
      if (rsp_next_pc !== e.next_pc) begin
         $error("next_pc exp %0d got %0d", e.next_pc, rsp_next_pc);
         failures++;
      end
      if (rsp_out_valid !== e.out_valid) begin
         $error("out_valid exp %0d got %0d", e.out_valid, rsp_out_valid);
         failures++;
      end
      if (rsp_out_value !== e.out_value) begin
         $error("out_value exp %h got %h", e.out_value, rsp_out_value);
         failures++;
      end
      if (rsp_halted !== e.halted) begin
         $error("halted exp %0d got %0d", e.halted, rsp_halted);
         failures++;
      end
      if (rsp_fault_code !== e.fault_code) begin
         $error("fault_code exp %0d got %0d", e.fault_code, rsp_fault_code);
         failures++;
      end
   endtask

   initial begin
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) check_beat();
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // picks a legal instruction for the current machine state
   task automatic pick_instr(output logic [3:0] op, output logic [2:0] lv,
                             output logic [WORD_W-1:0] mod);
      int k;
      int a;
      int b;
      int lo;
      int hi;
      bit done;
      done = 1'b0;
      while (!done) begin
         k = $urandom_range(0, 99);
         lv = 3'($urandom);
         mod = $urandom;
         done = 1'b1;
         if (k < 14) begin
            op = OP_LIT;
            if ($urandom_range(0, 1)) mod = $urandom_range(0, DEPTH - 1);
            if (m_sp >= 500) done = 1'b0;
         end else if (k < 34) begin
            op = OP_OPR;
            mod = $urandom_range(1, 10);
            if (m_sp < 1) done = 1'b0;
            else if (mod == OPR_DIV && m_mem[m_sp] == 0) done = 1'b0;
         end else if (k < 54) begin
            op = (k < 46) ? OP_LOD : OP_STO;
            if ((op == OP_LOD && m_sp >= 500) || (op == OP_STO && m_sp < 0))
               done = 1'b0;
            else begin
               if (!walk_ok(m_fb, lv, b)) begin
                  lv = 0;
                  b = m_fb;
               end
               a = $urandom_range(0, DEPTH - 1);
               mod = a - b;
            end
         end else if (k < 60) begin
            op = OP_CAL;
            if (m_sp + 3 >= DEPTH) done = 1'b0;
            else if (!walk_ok(m_fb, lv, b)) lv = 0;
         end else if (k < 66) begin
            op = OP_RTN;
            if (!return_ok()) done = 1'b0;
         end else if (k < 74) begin
            op = OP_INC;
            lo = -(m_sp + 1);
            hi = DEPTH - 1 - m_sp;
            if ($urandom_range(0, 9) == 0) a = lo + int'($urandom_range(0, hi - lo));
            else a = int'($urandom_range(0, 12)) - 8;
            if (a < lo) a = lo;
            if (a > hi) a = hi;
            mod = a;
         end else if (k < 80) op = OP_JMP;
         else if (k < 88) begin
            op = OP_JPC;
            if (m_sp < 0) done = 1'b0;
         end else if (k < 94) begin
            op = OP_SYS;
            mod = SYS_WRITE;
            if (m_sp < 0) done = 1'b0;
         end else begin
            op = OP_SYS;
            mod = SYS_READ;
            if (m_sp >= DEPTH - 1) done = 1'b0;
         end
      end
   endtask

   task automatic test_arithmetic();
      logic [WORD_W-1:0] operand [9];
      int                sub_op;
      operand = '{32'h7fff_ffff, 32'h8000_0000, 32'd7, 32'hffff_fffd, 32'd0,
                  32'hffff_ffff, 32'd1, 32'h8000_0000, 32'h7fff_ffff};
      send_instr(OP_LIT, 0, 32'h8000_0000, $urandom);
      send_instr(OP_LIT, 0, 32'hffff_ffff, $urandom);
      send_instr(OP_OPR, 0, OPR_DIV, $urandom);
      for (int i = 0; i < 9; i++) begin
         sub_op = (i < 3) ? i + 1 : i + 2;
         send_instr(OP_LIT, 0, operand[i], $urandom);
         send_instr(OP_OPR, 0, sub_op, $urandom);
      end
      send_instr(OP_SYS, 0, SYS_WRITE, $urandom);
      send_instr(OP_SYS, 0, SYS_READ, 32'h8000_0001);
   endtask

   task automatic test_frames();
      send_instr(OP_CAL, 0, 32'd100, $urandom);
      send_instr(OP_LOD, 1, 32'd0, $urandom);
      send_instr(OP_RTN, 0, 32'd0, $urandom);
   endtask

   task automatic test_random(input int count);
      logic [3:0]        op;
      logic [2:0]        lv;
      logic [WORD_W-1:0] mod;
      repeat (count) begin
         pick_instr(op, lv, mod);
         send_instr(op, lv, mod, $urandom);
      end
   endtask

   task automatic test_backpressure();
      wait_results_done();
      @(posedge clock);
      hold_req = 1'b1;
      test_random(20);
      wait_results_done();
      @(posedge clock);
   endtask

   task automatic test_halt_and_ignore();
      int k;
      case ($urandom_range(0, 3))
         0: send_instr(OP_SYS, 0, SYS_HALT, $urandom);
         1: begin
            send_instr(OP_LIT, 0, 32'd5, $urandom);
            send_instr(OP_LIT, 0, 32'd0, $urandom);
            send_instr(OP_OPR, 0, OPR_DIV, $urandom);
         end
         2: send_instr(OP_INC, 0, -(m_sp + 2), $urandom);
         default: begin
            k = $urandom_range(0, 6);
            if (k == 6) send_instr(OP_OPR, 0, 32'd11, $urandom);
            else send_instr((k == 0) ? 4'(k) : 4'(10 + k), 0, $urandom, $urandom);
         end
      endcase
      repeat (6) send_instr(4'($urandom), 3'($urandom), $urandom, $urandom);
   endtask

   initial begin
      failures       = 0;
      quiet          = 1'b0;
      hold_req       = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= '0;
      req_level      <= '0;
      req_modifier   <= '0;
      req_read_value <= '0;
      rsp_stall      <= 1'b0;
      for (int i = 0; i < DEPTH; i++) m_mem[i] = '0;
      m_sp     = -1;
      m_fb     = 0;
      m_pc     = 0;
      m_halted = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_arithmetic();
      test_frames();
      test_random(800);
      test_backpressure();
      test_random(900);
      quiet = 1'b1;
      test_random(80);
      test_halt_and_ignore();
      wait_results_done();
      repeat (60) @(posedge clock);
      if (failures == 0) $display("[pm0_stack_machine_step_unit] OK");
      else $display("[pm0_stack_machine_step_unit] ERROR");
      $finish;
   end

endmodule
